// ===== hdl/sle_pkg.sv =====
// Shared constants, codes and control structs for the sorted list engine.
package sle_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DELETED   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE    = 3'd0,
      S_COMPARE = 3'd1,
      S_FIND    = 3'd2,
      S_APPLY   = 3'd3,
      S_RESPOND = 3'd4
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       compare;
      logic       find;
      logic       apply;
      op_type     op;
      status_type status;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             found;
      logic             full;
   } dp_stat_type;

endpackage

// ===== hdl/sle_if.sv =====
// Valid/ready channel interfaces for the request and response items.
interface sle_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic signed [31:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface sle_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [4:0] entry_count;

   modport source (output valid, output status, output entry_count, input ready);
   modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== hdl/sle_ctrl.sv =====
// Sequencer for the sorted list engine: accept, compare, find, apply, respond.
module sle_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sle_pkg::dp_stat_type stat,
   output sle_pkg::ctrl_cmd_type cmd
);
   import sle_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_COMPARE;
         end
         S_COMPARE: state_in = S_FIND;
         S_FIND:    state_in = S_APPLY;
         S_APPLY:   state_in = S_RESPOND;
         S_RESPOND: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      cmd.op      = OP_NONE;
      cmd.status  = ST_NOT_FOUND;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_COMPARE: cmd.compare = 1'b1;
         S_FIND:    cmd.find = 1'b1;
         S_APPLY: begin
            cmd.apply = 1'b1;
            case (stat.command)
               CMD_INSERT: begin
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.op     = OP_INSERT;
                     cmd.status = ST_INSERTED;
                  end
               end
               CMD_SEARCH: begin
                  if (stat.found) cmd.status = ST_FOUND;
               end
               CMD_DELETE: begin
                  if (stat.found) begin
                     cmd.op     = OP_DELETE;
                     cmd.status = ST_DELETED;
                  end
               end
               default: cmd.status = ST_NOT_FOUND;
            endcase
         end
         S_RESPOND: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/sle_datapath.sv =====
// Row of compare-and-shift cells holding the sorted entries, plus count and result.
module sle_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sle_pkg::ctrl_cmd_type         cmd,
   input  logic [sle_pkg::CMD_W-1:0]     req_command,
   input  logic signed [sle_pkg::VALUE_W-1:0] req_value,
   output sle_pkg::dp_stat_type          stat,
   output logic [sle_pkg::STAT_W-1:0]    rsp_status,
   output logic [sle_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import sle_pkg::*;

   logic [CMD_W-1:0]          cmd_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] entries_in [DEPTH];
   logic [DEPTH-1:0]          lt_in;
   logic [DEPTH-1:0]          lt_ff;
   logic [DEPTH-1:0]          match_in;
   logic [DEPTH-1:0]          match_ff;
   logic                      found_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   status_type                status_ff;

   // Each cell compares against the held value and picks its next content locally.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic valid;
      assign valid = CNT_W'(i) < count_ff;
      assign lt_in[i] = valid && (entries_ff[i] < value_ff);
      if (i == 0) begin : g_first
         assign match_in[i] = valid && (entries_ff[i] == value_ff);
      end else begin : g_rest
         assign match_in[i] = valid && (entries_ff[i] == value_ff) && lt_in[i-1];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         case (cmd.op)
            OP_INSERT: begin
               if (i > 0 && !lt_ff[(i > 0) ? i-1 : 0]) begin
                  entries_in[i] = entries_ff[(i > 0) ? i-1 : 0];
               end else if (!lt_ff[i]) begin
                  entries_in[i] = value_ff;
               end
            end
            OP_DELETE: begin
               // close the gap from the matched slot upward
               if (i < DEPTH-1 && !lt_ff[i]) begin
                  entries_in[i] = entries_ff[(i < DEPTH-1) ? i+1 : i];
               end
            end
            default: entries_in[i] = entries_ff[i];
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      case (cmd.op)
         OP_INSERT: count_in = count_ff + CNT_W'(1);
         OP_DELETE: count_in = count_ff - CNT_W'(1);
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
      end
      if (cmd.compare) begin
         lt_ff    <= lt_in;
         match_ff <= match_in;
      end
      if (cmd.find) begin
         found_ff <= |match_ff;
      end
      if (cmd.apply) begin
         status_ff <= cmd.status;
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   assign stat.command = cmd_ff;
   assign stat.found   = found_ff;
   assign stat.full    = count_ff >= CNT_W'(DEPTH);

   assign rsp_status      = status_ff;
   assign rsp_entry_count = COUNT_W'(count_ff);

endmodule

// ===== hdl/sorted_list_engine.sv =====
// Sorted list engine: keeps up to DEPTH signed values in ascending order.
//
// Usage: each request item carries a command (insert, search, delete) and a
// signed 32-bit value on the req channel. Every request gives exactly one
// response item on the rsp channel with a status and the entry count after
// the operation. An insert goes before equal entries and is refused with a
// full status when the table holds DEPTH entries; a delete removes the first
// match. Command code 3 answers not found and changes nothing.
// Steps: after a request is accepted, all cells compare in the compare
// state, the find state folds the match bits, the apply state shifts
// the cells and updates the count, and the respond state shows the
// response. The sequencer takes one item at a time, so req.ready stays
// low until the response has been taken. A stalled response holds its
// payload.
// Reset: synchronous; clears the count, so the table reads empty. No
// clearing pass is needed and the block is ready the cycle after reset.
module sorted_list_engine (
   input logic       clock,
   input logic       reset,
   sle_req_if.sink   req,
   sle_rsp_if.source rsp
);
   import sle_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   sle_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .req_command     (req.command),
      .req_value       (req.value),
      .stat            (dp_stat),
      .rsp_status      (rsp.status),
      .rsp_entry_count (rsp.entry_count)
   );

endmodule

// ===== hdl/sle_checker.sv =====
// Port-level checks for the sorted list engine and their bind.
module sle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_entry_count
);
   import sle_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##4 rsp_valid)
      else $error("response not valid four cycles after request");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |-> rsp_entry_count != '0)
      else $error("insert reported with empty table");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_entry_count (rsp.entry_count)
);

// ===== tb/sv/tb_sorted_list_engine.sv =====
// Self-checking testbench for the sorted list engine: directed rows, then random traffic.
module tb_sorted_list_engine;
   import sle_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
   localparam logic signed [31:0]   VAL_MIN      = 32'sh8000_0000;
   localparam logic signed [31:0]   VAL_MAX      = 32'sh7FFF_FFFF;
   localparam int                   RANDOM_ITEMS = 1900;
   localparam int                   MAX_GAP      = 14;
   localparam int                   IDLE_LIMIT   = 2000;
   localparam int                   DRAIN_CYCLES = 8;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
   } list_result_type;

   typedef struct {
      logic [CMD_W-1:0]   command;
      logic signed [31:0] value;
      int                 reps;
      bit                 pinned;
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
   } stim_row_type;

   // pinned rows carry a hand-typed answer; the others go through the predictor
   stim_row_type directed_rows [22] = '{
      '{CMD_DELETE, 32'sd5,         1,  1'b1, ST_NOT_FOUND, 5'd0},
      '{CMD_SEARCH, 32'sd0,         1,  1'b1, ST_NOT_FOUND, 5'd0},
      '{CMD_UNUSED, 32'sd0,         1,  1'b1, ST_NOT_FOUND, 5'd0},
      '{CMD_INSERT, VAL_MAX,        1,  1'b1, ST_INSERTED,  5'd1},
      '{CMD_INSERT, VAL_MIN,        1,  1'b1, ST_INSERTED,  5'd2},
      '{CMD_INSERT, 32'sd0,         1,  1'b1, ST_INSERTED,  5'd3},
      '{CMD_INSERT, -32'sd1,        1,  1'b1, ST_INSERTED,  5'd4},
      '{CMD_INSERT, -32'sd1,        1,  1'b1, ST_INSERTED,  5'd5},
      '{CMD_SEARCH, VAL_MIN,        1,  1'b1, ST_FOUND,     5'd5},
      '{CMD_SEARCH, VAL_MAX,        1,  1'b1, ST_FOUND,     5'd5},
      '{CMD_UNUSED, VAL_MAX,        1,  1'b1, ST_NOT_FOUND, 5'd5},
      '{CMD_DELETE, -32'sd1,        1,  1'b1, ST_DELETED,   5'd4},
      '{CMD_DELETE, 32'sd7,         1,  1'b1, ST_NOT_FOUND, 5'd4},
      '{CMD_DELETE, VAL_MIN,        1,  1'b1, ST_DELETED,   5'd3},
      '{CMD_INSERT, 32'sh5555_5555, 1,  1'b0, ST_INSERTED,  5'd0},
      '{CMD_INSERT, 32'shAAAA_AAAA, 1,  1'b0, ST_INSERTED,  5'd0},
      '{CMD_INSERT, 32'sd100,       11, 1'b0, ST_INSERTED,  5'd0},
      '{CMD_INSERT, VAL_MIN,        1,  1'b1, ST_FULL,      5'd16},
      '{CMD_SEARCH, 32'sd100,       1,  1'b1, ST_FOUND,     5'd16},
      '{CMD_DELETE, 32'sd100,       1,  1'b1, ST_DELETED,   5'd15},
      '{CMD_DELETE, VAL_MAX,        1,  1'b1, ST_DELETED,   5'd14},
      '{CMD_INSERT, 32'sh7FFF_FFFE, 1,  1'b0, ST_INSERTED,  5'd0}
   };

   logic clock = 1'b0;
   logic reset;

   sle_req_if req_bus ();
   sle_rsp_if rsp_bus ();

   sorted_list_engine u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state: ascending table and its fill level
   logic signed [31:0] model_entries [DEPTH];
   int                 model_fill = 0;
   list_result_type    pending_outcomes [$];
   logic signed [31:0] value_pool [8];

   // answer held next to the request payload for pinned rows
   logic               pin_valid;
   status_type         pin_status;
   logic [COUNT_W-1:0] pin_count;

   int  mismatches  = 0;
   int  idle_cycles = 0;
   bit  send_burst  = 1'b0;
   bit  take_burst  = 1'b0;

   function automatic list_result_type apply_list_op(logic [CMD_W-1:0] command,
                                                     logic signed [31:0] value);
      list_result_type outcome;
      int              slot;
      outcome.status = ST_NOT_FOUND;
      slot = 0;
      while (slot < model_fill && model_entries[slot] < value) slot++;
      case (command)
         CMD_INSERT: begin
            if (model_fill >= DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               for (int j = model_fill; j > slot; j--) model_entries[j] = model_entries[j-1];
               model_entries[slot] = value;
               model_fill++;
               outcome.status = ST_INSERTED;
            end
         end
         CMD_SEARCH: begin
            if (slot < model_fill && model_entries[slot] == value) outcome.status = ST_FOUND;
         end
         CMD_DELETE: begin
            if (slot < model_fill && model_entries[slot] == value) begin
               for (int j = slot; j + 1 < model_fill; j++) model_entries[j] = model_entries[j+1];
               model_fill--;
               outcome.status = ST_DELETED;
            end
         end
         default: ;
      endcase
      outcome.entry_count = COUNT_W'(model_fill);
      return outcome;
   endfunction

   function automatic logic signed [31:0] pick_value(bit from_table);
      int k;
      if (from_table && model_fill > 0 && $urandom_range(0, 1) == 1)
         return model_entries[$urandom_range(0, model_fill - 1)];
      k = $urandom_range(0, 15);
      if (k == 0) return VAL_MIN;
      if (k == 1) return VAL_MAX;
      if (k <= 4) return $urandom;
      return value_pool[$urandom_range(0, 7)];
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (r < (filling ? 55 : 25)) return CMD_INSERT;
      if (r < (filling ? 70 : 40)) return CMD_SEARCH;
      if (r < 95) return CMD_DELETE;
      return CMD_UNUSED;
   endfunction

   task automatic send_item(logic [CMD_W-1:0] command, logic signed [31:0] value,
                            bit pinned, status_type status, logic [COUNT_W-1:0] count);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= command;
      req_bus.value   <= value;
      pin_valid       <= pinned;
      pin_status      <= status;
      pin_count       <= count;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // stimulus
   initial begin
      int  sent;
      int  phase_len;
      int  phase_idx;
      bit  filling;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.command <= CMD_INSERT;
      req_bus.value   <= '0;
      pin_valid       <= 1'b0;
      pin_status      <= ST_INSERTED;
      pin_count       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps)
            send_item(directed_rows[i].command, directed_rows[i].value,
                      directed_rows[i].pinned, directed_rows[i].status,
                      directed_rows[i].entry_count);
      end

      sent      = 0;
      phase_idx = 0;
      filling   = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         // hold off until the engine has answered everything in flight
         if (phase_idx == 0 || $urandom_range(0, 1) == 1) begin
            req_bus.valid <= 1'b0;
            wait_drained();
         end
         filling    = !filling;
         send_burst = ($urandom_range(0, 3) == 0);
         phase_len  = $urandom_range(30, 90);
         foreach (value_pool[i])
            value_pool[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40) - 20;
         repeat (phase_len) begin
            logic [CMD_W-1:0] command;
            command = pick_command(filling);
            send_item(command, pick_value(command != CMD_INSERT), 1'b0, ST_INSERTED, '0);
            sent++;
         end
         phase_idx++;
      end
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // response side stalls
   initial begin
      int stall;
      int taken;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      taken = 0;
      forever begin
         if (taken % 40 == 0) take_burst = ($urandom_range(0, 3) == 0);
         stall = take_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         taken++;
      end
   end

   // predict on request, compare on response, watch for a hang
   always @(posedge clock) begin
      list_result_type due;
      bit              moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            due = apply_list_op(req_bus.command, req_bus.value);
            if (pin_valid) begin
               due.status      = pin_status;
               due.entry_count = pin_count;
            end
            pending_outcomes.push_back(due);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected response, status %0d count %0d", $time,
                        rsp_bus.status, rsp_bus.entry_count);
               mismatches++;
            end else begin
               due = pending_outcomes.pop_front();
               if (rsp_bus.status !== due.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                           due.status, rsp_bus.status);
                  mismatches++;
               end
               if (rsp_bus.entry_count !== due.entry_count) begin
                  $display("%0t: entry_count mismatch, expected %0d, actual %0d", $time,
                           due.entry_count, rsp_bus.entry_count);
                  mismatches++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule
